/* rtl/fwdf_pkg.sv */
// shared types and constants for the fixed-width decimal formatter
package fwdf_pkg;

   localparam int unsigned MAX_DIGITS = 10;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned BCD_W      = 4;
   localparam int unsigned COUNT_W    = 4;
   localparam int unsigned BIT_CNT_W  = 5;

   localparam logic [5:0] CH_ZERO  = 6'd48;
   localparam logic [5:0] CH_MINUS = 6'd45;

   // control that every cell of the bcd chain sees
   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

/* rtl/fwdf_bcd_cell.sv */
// one decimal digit of the shift-add-3 chain
module fwdf_bcd_cell
   import fwdf_pkg::*;
(
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic              carry_in,
   output logic              carry_out,
   output logic [BCD_W-1:0]  digit
);

   logic [BCD_W-1:0] digit_ff;
   logic [BCD_W-1:0] digit_in;
   logic [BCD_W-1:0] adjusted;

   // add 3 before the shift so a digit of 5 or more carries into the neighbor
   always_comb begin
      if (digit_ff >= BCD_W'(5)) begin
         adjusted = digit_ff + BCD_W'(3);
      end else begin
         adjusted = digit_ff;
      end
   end

   assign carry_out = adjusted[BCD_W-1];

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.shift) begin
         digit_in = {adjusted[BCD_W-2:0], carry_in};
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

/* rtl/fixed_width_decimal_formatter_unit.sv */
// top level: value to fixed-width ascii decimal, one character per transfer
//
// One input transfer is converted by a row of ten bcd digit cells that shift the
// magnitude in one bit a cycle with add-3 correction until every bit is in, then
// emits an optional '-' and the low N digits (N = digit_count saturated to 10),
// most significant first, one character a cycle while rsp_stall is low. An item
// that emits nothing still passes through the emit state. req_stall stays high
// until the item's last character sits in the output register. A negative signed
// value with a digit count of zero gives the single '-' with last_char set; a
// non-negative value with a digit count of zero gives no transfer at all.
module fixed_width_decimal_formatter_unit
   import fwdf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [VALUE_W-1:0]  req_raw_value,
   input  logic                req_signed_flag,
   input  logic [7:0]          req_digit_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [5:0]          rsp_char_code,
   output logic [COUNT_W-1:0]  rsp_char_position,
   output logic                rsp_last_char
);

   state_type              state_ff, state_in;
   logic [VALUE_W-1:0]     mag_ff, mag_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic                   sign_pend_ff, sign_pend_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     remain_ff, remain_in;
   logic [COUNT_W-1:0]     pos_ff, pos_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [5:0]             code_ff, code_in;
   logic [COUNT_W-1:0]     out_pos_ff, out_pos_in;
   logic                   last_ff, last_in;

   cell_ctrl_type          ctrl;
   logic [MAX_DIGITS:0]    carry;
   logic [BCD_W-1:0]       digits [MAX_DIGITS];

   logic                   accept;
   logic                   neg;
   logic                   out_free;
   logic [COUNT_W-1:0]     sel;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign neg       = req_signed_flag && req_raw_value[VALUE_W-1];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sel       = remain_ff - COUNT_W'(1);

   assign ctrl.clear = accept;
   assign ctrl.shift = (state_ff == ST_CONV);

   // magnitude enters the low cell msb first
   assign carry[0] = mag_ff[VALUE_W-1];

   for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
      fwdf_bcd_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .carry_in  (carry[g]),
         .carry_out (carry[g+1]),
         .digit     (digits[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bit_cnt_in   = bit_cnt_ff;
      sign_pend_in = sign_pend_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      code_in      = code_ff;
      out_pos_in   = out_pos_ff;
      last_in      = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mag_in       = neg ? (~req_raw_value + VALUE_W'(1)) : req_raw_value;
               bit_cnt_in   = '0;
               sign_pend_in = neg;
               if (req_digit_count > 8'(MAX_DIGITS)) begin
                  count_in = COUNT_W'(MAX_DIGITS);
               end else begin
                  count_in = req_digit_count[COUNT_W-1:0];
               end
               remain_in    = count_in;
               pos_in       = '0;
               state_in     = ST_CONV;
            end
         end
         ST_CONV: begin
            mag_in     = {mag_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!sign_pend_ff && remain_ff == '0) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               out_pos_in   = pos_ff;
               pos_in       = pos_ff + COUNT_W'(1);
               if (sign_pend_ff) begin
                  code_in      = CH_MINUS;
                  last_in      = (count_ff == '0);
                  sign_pend_in = 1'b0;
                  if (count_ff == '0) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  code_in   = CH_ZERO + {2'b00, digits[sel]};
                  last_in   = (remain_ff == COUNT_W'(1));
                  remain_in = remain_ff - COUNT_W'(1);
                  if (remain_ff == COUNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff       <= mag_in;
      bit_cnt_ff   <= bit_cnt_in;
      sign_pend_ff <= sign_pend_in;
      count_ff     <= count_in;
      remain_ff    <= remain_in;
      pos_ff       <= pos_in;
      code_ff      <= code_in;
      out_pos_ff   <= out_pos_in;
      last_ff      <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_code     = code_ff;
   assign rsp_char_position = out_pos_ff;
   assign rsp_last_char     = last_ff;

endmodule
